// ===== hw/rtl/cfcc_pkg.sv =====
// Package for the colon-framed CRC-16 reply checker.
// Holds character codes, field counts, the CRC byte step, the blank and digit helpers
// and the word types shared by the submodules and the top level. No dependencies.
package cfcc_pkg;

  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [3:0]  FieldsOld = 4'd7;
  localparam logic [3:0]  FieldsNew = 4'd11;
  localparam logic [3:0]  FieldsMax = 4'd15;

  localparam logic [7:0] ColonChar = 8'h3A;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] MinusChar = 8'h2D;

  // Digit code for a byte that is no hex digit
  localparam logic [4:0] DigitNone = 5'd16;
  localparam logic [4:0] DecBase   = 5'd10;

  typedef struct packed {
    logic [15:0] hex_val;
    logic [15:0] dec_val;
  } tail_val_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] sum_inv;
    logic [3:0]  fields;
  } frame_sum_t;

  // Reflected CRC-16 update by one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20) || (b == 8'h85) || (b == 8'hA0);
  endfunction

  function automatic logic [4:0] digit_value(input logic [7:0] b);
    logic [4:0] d;
    d = DigitNone;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      d = 5'(b - 8'h30);
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      d = 5'(b - 8'h61 + 8'd10);
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      d = 5'(b - 8'h41 + 8'd10);
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/cfcc_tail_reader.sv =====
// Final-field reader: parses the text after the last colon as hex and as
// signed decimal, trimming whitespace. Depends on cfcc_pkg.
module cfcc_tail_reader import cfcc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      eof_i,
  input  logic [7:0] byte_i,
  output tail_val_t val_o
);

  localparam logic [1:0] PhLead  = 2'd0;
  localparam logic [1:0] PhSign  = 2'd1;
  localparam logic [1:0] PhValue = 2'd2;
  localparam logic [1:0] PhTrail = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [15:0] hex_acc_q, hex_acc_d;
  logic        hex_inv_q, hex_inv_d;
  logic [15:0] dec_acc_q, dec_acc_d;
  logic        dec_neg_q, dec_neg_d;
  logic        dec_inv_q, dec_inv_d;

  logic [4:0]  digit;
  logic [15:0] dec_times10;
  logic        fin_hex_inv, fin_dec_inv;

  assign digit       = digit_value(byte_i);
  assign dec_times10 = {dec_acc_q[12:0], 3'b000} + {dec_acc_q[14:0], 1'b0};

  always_comb begin
    phase_d   = phase_q;
    hex_acc_d = hex_acc_q;
    hex_inv_d = hex_inv_q;
    dec_acc_d = dec_acc_q;
    dec_neg_d = dec_neg_q;
    dec_inv_d = dec_inv_q;
    priority if (byte_i == ColonChar) begin
      phase_d   = PhLead;
      hex_acc_d = '0;
      hex_inv_d = 1'b0;
      dec_acc_d = '0;
      dec_neg_d = 1'b0;
      dec_inv_d = 1'b0;
    end else if (is_blank(byte_i)) begin
      if (phase_q == PhSign) begin
        dec_inv_d = 1'b1;
        phase_d   = PhTrail;
      end else if (phase_q == PhValue) begin
        phase_d = PhTrail;
      end
    end else if (phase_q == PhTrail) begin
      hex_inv_d = 1'b1;
      dec_inv_d = 1'b1;
    end else if ((byte_i == PlusChar) || (byte_i == MinusChar)) begin
      if (phase_q == PhLead) begin
        phase_d   = PhSign;
        dec_neg_d = (byte_i == MinusChar);
        hex_inv_d = 1'b1;
      end else begin
        hex_inv_d = 1'b1;
        dec_inv_d = 1'b1;
      end
    end else begin
      phase_d = PhValue;
      if (digit != DigitNone) begin
        if (hex_acc_q > 16'h0FFF) begin
          hex_inv_d = 1'b1;
        end else begin
          hex_acc_d = {hex_acc_q[11:0], digit[3:0]};
        end
      end else begin
        hex_inv_d = 1'b1;
      end
      if (digit < DecBase) begin
        dec_acc_d = dec_times10 + {12'h000, digit[3:0]};
      end else begin
        dec_inv_d = 1'b1;
      end
    end
  end

  // Empty field or bare sign reads as unreadable
  assign fin_hex_inv = hex_inv_d | ~phase_d[1];
  assign fin_dec_inv = dec_inv_d | ~phase_d[1];

  assign val_o.hex_val = fin_hex_inv ? 16'h0000 : hex_acc_d;
  assign val_o.dec_val = fin_dec_inv ? 16'h0000 :
                         (dec_neg_d ? (16'h0000 - dec_acc_d) : dec_acc_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhLead;
      hex_acc_q <= '0;
      hex_inv_q <= 1'b0;
      dec_acc_q <= '0;
      dec_neg_q <= 1'b0;
      dec_inv_q <= 1'b0;
    end else if (en_i) begin
      if (eof_i) begin
        phase_q   <= PhLead;
        hex_acc_q <= '0;
        hex_inv_q <= 1'b0;
        dec_acc_q <= '0;
        dec_neg_q <= 1'b0;
        dec_inv_q <= 1'b0;
      end else begin
        phase_q   <= phase_d;
        hex_acc_q <= hex_acc_d;
        hex_inv_q <= hex_inv_d;
        dec_acc_q <= dec_acc_d;
        dec_neg_q <= dec_neg_d;
        dec_inv_q <= dec_inv_d;
      end
    end
  end

endmodule

// ===== hw/rtl/cfcc_sum_crc.sv =====
// Running CRC-16, byte sum and colon count, with the values latched at the
// last colon. Depends on cfcc_pkg.
module cfcc_sum_crc import cfcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       eof_i,
  input  logic [7:0] byte_i,
  output frame_sum_t sum_o
);

  logic [15:0] crc_q, crc_d;
  logic [15:0] sum_q, sum_d;
  logic [15:0] pend_crc_q, pend_crc_d;
  logic [15:0] pend_sum_q, pend_sum_d;
  logic [3:0]  colons_q, colons_d;
  logic        is_colon;

  assign is_colon = (byte_i == ColonChar);
  assign crc_d    = crc16_byte(crc_q, byte_i);
  assign sum_d    = sum_q + {8'h00, byte_i};

  always_comb begin
    colons_d   = colons_q;
    pend_crc_d = pend_crc_q;
    pend_sum_d = pend_sum_q;
    if (is_colon) begin
      if (colons_q != FieldsMax) begin
        colons_d = colons_q + 4'd1;
      end
      pend_crc_d = crc_d;
      pend_sum_d = sum_d;
    end
  end

  assign sum_o.crc     = pend_crc_d;
  assign sum_o.sum_inv = ~pend_sum_d;
  assign sum_o.fields  = (colons_d != FieldsMax) ? (colons_d + 4'd1) : FieldsMax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= '0;
      sum_q      <= '0;
      pend_crc_q <= '0;
      pend_sum_q <= '0;
      colons_q   <= '0;
    end else if (en_i) begin
      if (eof_i) begin
        crc_q      <= '0;
        sum_q      <= '0;
        pend_crc_q <= '0;
        pend_sum_q <= '0;
        colons_q   <= '0;
      end else begin
        crc_q      <= crc_d;
        sum_q      <= sum_d;
        pend_crc_q <= pend_crc_d;
        pend_sum_q <= pend_sum_d;
        colons_q   <= colons_d;
      end
    end
  end

endmodule

// ===== hw/rtl/colon_frame_crc16_checker_unit.sv =====
// Colon-framed reply checker, top level. An accepted word is registered in the
// input stage, and the end-of-frame word's result goes on to the output register.
// Throughput: one word per cycle unless an end-of-frame word waits on the output;
// CRC and sum update per byte finish in the single stage. One result word per frame.
// Reset clears all frame state, the mode register (mode 0) and both valids.
// Depends on cfcc_pkg, cfcc_sum_crc and cfcc_tail_reader.
module colon_frame_crc16_checker_unit import cfcc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_ok_o,
  output logic        crc_match_o,
  output logic        sum_match_o,
  output logic [15:0] computed_crc_o,
  output logic [15:0] computed_sum_o,
  output logic [3:0]  field_total_o
);

  logic       mode_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_eof_q;
  logic       out_valid_q;
  logic       out_free, s1_go, in_accept;

  tail_val_t  tail_val;
  frame_sum_t frame_sum;

  logic [15:0] field_val;
  logic [3:0]  fields_want;
  logic        crc_ok, sum_ok;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  // A word without end-of-frame needs no output slot
  assign s1_go      = s1_valid_q & (~s1_eof_q | out_free);
  assign in_stall_o = s1_valid_q & ~s1_go;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_eof_q  <= end_of_frame_i;
    end
  end

  cfcc_sum_crc u_sum_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_go),
    .eof_i  (s1_eof_q),
    .byte_i (s1_byte_q),
    .sum_o  (frame_sum)
  );

  cfcc_tail_reader u_tail (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_go),
    .eof_i  (s1_eof_q),
    .byte_i (s1_byte_q),
    .val_o  (tail_val)
  );

  assign field_val   = mode_q ? tail_val.hex_val : tail_val.dec_val;
  assign fields_want = mode_q ? FieldsNew : FieldsOld;
  assign crc_ok      = (field_val == frame_sum.crc);
  assign sum_ok      = (tail_val.hex_val == frame_sum.sum_inv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_eof_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_eof_q) begin
      frame_ok_o     <= (frame_sum.fields == fields_want) & (crc_ok | sum_ok);
      crc_match_o    <= crc_ok;
      sum_match_o    <= sum_ok;
      computed_crc_o <= frame_sum.crc;
      computed_sum_o <= frame_sum.sum_inv;
      field_total_o  <= frame_sum.fields;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/cfcc_checker.sv =====
// Port-level checker for the colon-framed reply checker, with its bind.
// Depends on colon_frame_crc16_checker_unit.
module cfcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        frame_ok_o,
  input logic        crc_match_o,
  input logic        sum_match_o,
  input logic [15:0] computed_crc_o,
  input logic [15:0] computed_sum_o,
  input logic [3:0]  field_total_o
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Back up the input only behind a stalled result word
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the output free");

  // A passing frame has a legal field count and at least one match
  a_ok_implies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_ok_o |->
      (field_total_o == 4'd7 || field_total_o == 4'd11) && (crc_match_o || sum_match_o))
    else $error("frame_ok without count or match");

  a_fields_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> field_total_o != 4'd0)
    else $error("field total of zero");

  // With no colon, CRC and sum cover nothing
  a_no_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_total_o == 4'd1 |->
      computed_crc_o == 16'h0000 && computed_sum_o == 16'hFFFF)
    else $error("CRC or sum nonzero for a frame without colon");

endmodule

bind colon_frame_crc16_checker_unit cfcc_checker u_cfcc_checker (.*);

// ===== test/colon_frame_crc16_checker_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for colon_frame_crc16_checker_unit: drives directed and random reply lines
// through valid/stall handshakes and checks every frame verdict against its own predictor.
// Depends on cfcc_pkg and the checker RTL.
module colon_frame_crc16_checker_unit_tb;
  import cfcc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int SegmentWords = 250;
  localparam int SegmentFrames = 10;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 6;
  localparam logic [7:0] BlankChars [8] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20,
                                            8'h85, 8'hA0};

  typedef enum logic [1:0] {TailLead, TailSign, TailValue, TailTrail} tail_phase_e;

  typedef struct packed {
    logic        frame_ok;
    logic        crc_match;
    logic        sum_match;
    logic [15:0] crc;
    logic [15:0] sum_inv;
    logic [3:0]  fields;
  } verdict_t;

  class frame_scoreboard;
    bit          mode;
    logic [15:0] crc_run, sum_run, crc_at_colon, sum_at_colon;
    logic [3:0]  colons;
    logic [15:0] hex_acc, dec_acc;
    bit          hex_bad, dec_bad, dec_neg;
    tail_phase_e phase;
    verdict_t    expected_verdicts[$];
    int          mismatches;
    int          frames_checked;

    function new();
      mode = 1'b0;
      mismatches = 0;
      frames_checked = 0;
      clear_frame();
    endfunction

    // Reflected CRC-16, one input bit at a time
    static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ b[k];
        c = c >> 1;
        if (fb) c = c ^ CrcPoly;
      end
      return c;
    endfunction

    static function bit blank(logic [7:0] b);
      return b inside {[8'h09:8'h0D], 8'h20, 8'h85, 8'hA0};
    endfunction

    function void clear_tail();
      hex_acc = '0;
      hex_bad = 1'b0;
      dec_acc = '0;
      dec_neg = 1'b0;
      dec_bad = 1'b0;
      phase = TailLead;
    endfunction

    function void clear_frame();
      crc_run = '0;
      sum_run = '0;
      crc_at_colon = '0;
      sum_at_colon = '0;
      colons = '0;
      clear_tail();
    endfunction

    function void tail_char(logic [7:0] b);
      logic [4:0] d;
      if (blank(b)) begin
        if (phase == TailSign) begin
          dec_bad = 1'b1;
          phase = TailTrail;
        end else if (phase == TailValue) begin
          phase = TailTrail;
        end
        return;
      end
      if (phase == TailTrail) begin
        hex_bad = 1'b1;
        dec_bad = 1'b1;
        return;
      end
      if (b == PlusChar || b == MinusChar) begin
        // a sign only counts in front of the value, and never in hex
        if (phase == TailLead) begin
          phase = TailSign;
          dec_neg = (b == MinusChar);
        end else begin
          dec_bad = 1'b1;
        end
        hex_bad = 1'b1;
        return;
      end
      phase = TailValue;
      if (b >= "0" && b <= "9") d = 5'(b - "0");
      else if (b >= "a" && b <= "f") d = 5'(b - "a" + 8'd10);
      else if (b >= "A" && b <= "F") d = 5'(b - "A" + 8'd10);
      else d = DigitNone;
      if (d == DigitNone) hex_bad = 1'b1;
      else if (hex_acc > 16'h0FFF) hex_bad = 1'b1;
      else hex_acc = {hex_acc[11:0], d[3:0]};
      if (d < DecBase) dec_acc = dec_acc * 16'(DecBase) + 16'(d);
      else dec_bad = 1'b1;
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
      logic [15:0] hex_val, dec_val, field_val;
      verdict_t    v;
      crc_run = crc_step(crc_run, b);
      sum_run = sum_run + {8'h00, b};
      if (b == ColonChar) begin
        if (colons != FieldsMax) colons++;
        crc_at_colon = crc_run;
        sum_at_colon = sum_run;
        clear_tail();
      end else begin
        tail_char(b);
      end
      if (!eof) return;
      if (phase < TailValue) begin
        hex_bad = 1'b1;
        dec_bad = 1'b1;
      end
      hex_val = hex_bad ? 16'h0000 : hex_acc;
      dec_val = dec_bad ? 16'h0000 : (dec_neg ? 16'(16'h0000 - dec_acc) : dec_acc);
      field_val = mode ? hex_val : dec_val;
      v.crc = crc_at_colon;
      v.sum_inv = ~sum_at_colon;
      v.fields = (colons == FieldsMax) ? FieldsMax : colons + 4'd1;
      v.crc_match = (field_val == crc_at_colon);
      v.sum_match = (hex_val == v.sum_inv);
      v.frame_ok = (v.fields == (mode ? FieldsNew : FieldsOld)) && (v.crc_match || v.sum_match);
      expected_verdicts.push_back(v);
      clear_frame();
    endfunction

    function void compare(string name, logic [15:0] want, logic [15:0] seen);
      if (seen !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(verdict_t got);
      verdict_t exp_v;
      if (expected_verdicts.size() == 0) begin
        $error("result word arrived with no frame pending");
        mismatches++;
        return;
      end
      exp_v = expected_verdicts.pop_front();
      frames_checked++;
      compare("frame_ok", exp_v.frame_ok, got.frame_ok);
      compare("crc_match", exp_v.crc_match, got.crc_match);
      compare("sum_match", exp_v.sum_match, got.sum_match);
      compare("computed_crc", exp_v.crc, got.crc);
      compare("computed_sum", exp_v.sum_inv, got.sum_inv);
      compare("field_total", exp_v.fields, got.fields);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        end_of_frame_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        frame_ok_o;
  logic        crc_match_o;
  logic        sum_match_o;
  logic [15:0] computed_crc_o;
  logic [15:0] computed_sum_o;
  logic [3:0]  field_total_o;

  frame_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          stall_hold_left = 0;
  int          words_sent = 0;
  int          cycle_count = 0;
  bit          cur_mode = 1'b0;
  logic [7:0]  frame_bytes[$];
  string       junk_chars = "0123456789abcdefABCDEFgG+- \t";

  colon_frame_crc16_checker_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_ok_o     (frame_ok_o),
    .crc_match_o    (crc_match_o),
    .sum_match_o    (sum_match_o),
    .computed_crc_o (computed_crc_o),
    .computed_sum_o (computed_sum_o),
    .field_total_o  (field_total_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: a long hold-off wins over the random stall
  always @(posedge clk_i) begin
    if (stall_hold_left > 0) begin
      out_stall_i <= 1'b1;
      stall_hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check results before noting inputs: an output never belongs to a word taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_result({frame_ok_o, crc_match_o, sum_match_o, computed_crc_o, computed_sum_o,
                         field_total_o});
      if (in_valid_i && !in_stall_o) sb.note_byte(data_byte_i, end_of_frame_i);
    end
  end

  task automatic drive_word(logic [7:0] b, logic eof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    end_of_frame_i <= eof;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++)
      drive_word(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic send_text(string s);
    frame_bytes.delete();
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
    send_frame();
  endtask

  // Drain all results, then give the pipeline time to finish words that make none
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(bit m);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
    sb.mode = m;
  endtask

  function automatic logic [7:0] junk_char();
    return junk_chars[$urandom_range(junk_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] filler_char();
    logic [7:0] b;
    do begin
      if ($urandom_range(9) < 7) b = 8'($urandom_range(8'h7E, 8'h21));
      else b = 8'($urandom_range(255));
    end while (b == ColonChar);
    return b;
  endfunction

  function automatic void push_dec(int unsigned v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(8'("0" + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) frame_bytes.push_back(digs[i]);
  endfunction

  function automatic void push_hex(int unsigned v, int ndig);
    int unsigned nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = (v >> (4 * i)) & 4'hF;
      if (nib < 10) frame_bytes.push_back(8'("0" + nib));
      else frame_bytes.push_back(8'(($urandom_range(1) ? "A" : "a") + nib - 10));
    end
  endfunction

  // Write v the way a sender might: hex with optional leading zeros, or decimal
  // plain, signed, negative or overflowed by whole multiples of 65536
  function automatic void push_value(bit as_hex, int unsigned v);
    int n;
    if (as_hex) begin
      n = 1;
      while (n < 8 && (v >> (4 * n)) != 0) n++;
      push_hex(v, n + $urandom_range(2));
    end else begin
      case ($urandom_range(3))
        0: push_dec(v);
        1: begin
          frame_bytes.push_back(PlusChar);
          push_dec(v);
        end
        2: begin
          frame_bytes.push_back(MinusChar);
          push_dec(65536 * $urandom_range(3, 1) - v);
        end
        default: push_dec(v + 65536 * $urandom_range(5, 1));
      endcase
    end
  endfunction

  function automatic void build_frame();
    int          nfields;
    int          pick;
    logic [15:0] crc;
    logic [15:0] sum;
    logic [15:0] sum_inv;
    frame_bytes.delete();
    nfields = ($urandom_range(9) < 8) ? (cur_mode ? 11 : 7) : $urandom_range(18, 1);
    for (int f = 1; f < nfields; f++) begin
      repeat ($urandom_range(4)) frame_bytes.push_back(filler_char());
      frame_bytes.push_back(ColonChar);
    end
    crc = '0;
    sum = '0;
    foreach (frame_bytes[i]) begin
      crc = frame_scoreboard::crc_step(crc, frame_bytes[i]);
      sum = sum + {8'h00, frame_bytes[i]};
    end
    sum_inv = ~sum;
    if ($urandom_range(2) == 0)
      repeat ($urandom_range(3, 1)) frame_bytes.push_back(BlankChars[$urandom_range(7)]);
    pick = $urandom_range(99);
    if (pick < 35) begin
      push_value(cur_mode, crc);
    end else if (pick < 60) begin
      push_value(1'b1, sum_inv);
    end else if (pick < 70) begin
      push_value(cur_mode, crc ^ (16'h0001 << $urandom_range(15)));
    end else if (pick < 80) begin
      push_hex($urandom, $urandom_range(6, 1));
    end else if (pick < 88) begin
      if ($urandom_range(1)) frame_bytes.push_back($urandom_range(1) ? PlusChar : MinusChar);
      push_dec($urandom_range(999999));
    end else if (pick < 95) begin
      repeat ($urandom_range(4, 1)) frame_bytes.push_back(junk_char());
    end
    // otherwise leave the final field empty
    if ($urandom_range(2) == 0)
      repeat ($urandom_range(3, 1)) frame_bytes.push_back(BlankChars[$urandom_range(7)]);
    if ($urandom_range(19) == 0) frame_bytes.push_back(junk_char());
  endfunction

  initial begin
    int seg;
    int seg_start;
    int seg_frames;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    drive_word(8'h00, 1'b1);
    drive_word(8'hFF, 1'b1);
    send_text(":");
    send_text(" -");
    send_text("7: +12 ");
    send_text("::-0");
    send_text("x:FFFFF");
    send_text("1 2");

    // Sender-idle/receiver-stall profiles in pairs, alternating the protocol mode
    for (seg = 0; seg < 6; seg++) begin
      wait_idle();
      case (seg / 2)
        0: begin
          send_idle_pct = 7;
          recv_stall_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_stall_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      write_mode(1'(seg % 2));
      if (seg == 4) begin
        // hold the output back and keep feeding one-byte frames until the input backs up
        stall_hold_left = HoldCycles;
        repeat (40) drive_word(8'($urandom_range(255)), 1'b1);
      end
      seg_start = words_sent;
      seg_frames = 0;
      while (words_sent - seg_start < SegmentWords || seg_frames < SegmentFrames) begin
        build_frame();
        send_frame();
        seg_frames++;
      end
    end
    wait_idle();

    $display("Checked %0d frame verdicts from %0d input bytes, %0d mismatches.",
             sb.frames_checked, words_sent, sb.mismatches);
    $display("Both protocol modes, three handshake profiles and one long output hold-off.");
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
